// File: design/enmf_pkg.sv
// Shared constants for the eight-neighbour mean filter.
// Field widths, register indexes and opcodes; no dependencies.
package enmf_pkg;

  localparam int MAX_COLS_DEF   = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int MAX_ROWS   = 4096;
  localparam int ROW_W      = 12;
  localparam int COL_IDX_W  = 10;
  localparam int MEAN_W     = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

endpackage

// File: design/enmf_ring_ram.sv
// Ring of four line buffers for the eight-neighbour mean filter.
// Single-port-per-direction synchronous RAM with registered read data; no dependencies.
module enmf_ring_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/eight_neighbor_mean_filter.sv
// Top level of the eight-neighbour mean filter over a raster pixel stream.
// Depends on enmf_pkg and enmf_ring_ram.
//
// Pixels arrive in raster order on the in_ stream (tuser low = pixel, high = drain tick);
// each result gives the truncated mean of the in-frame 3x3 neighbours of one position,
// centre excluded, with its row and column, and tlast on the last position of the frame.
// A result falls due once its last neighbour has arrived; drain ticks flush the rest.
// Rows live in a four-row ring store of 4 x MAX_COLS entries. An item that causes no
// result is taken without a stall; an item that causes a result holds off further items through
// the transfer, eight neighbour reads through the single read port of the ring store, a state
// for the last read data, one reciprocal multiply and one output load, plus any wait while the
// output register is not taken. A write to either frame register restarts the frame.
module eight_neighbor_mean_filter
  import enmf_pkg::*;
#(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] pixel
  input  logic                  in_tuser,   // [0] op
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] mean, [19:8] row_index, [29:20] col_index
  output logic                  out_tlast   // frame_end
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int AW    = 2 + COL_W;
  localparam int SW    = PIXEL_BITS + 3;
  localparam int K     = SW + 3;
  localparam int RW    = K + 1;
  localparam int PW    = SW + RW;
  localparam int QW    = (PIXEL_BITS > MEAN_W) ? PIXEL_BITS : MEAN_W;
  localparam int CW    = (COL_W > COL_IDX_W) ? COL_W : COL_IDX_W;

  localparam logic [COL_W-1:0] COLS_MAX_M1 = COL_W'(MAX_COLS - 1);

  localparam logic [RW-1:0] RCP1 = RW'(64'd1 << K);
  localparam logic [RW-1:0] RCP2 = RW'(((64'd1 << K) + 64'd1) / 64'd2);
  localparam logic [RW-1:0] RCP3 = RW'(((64'd1 << K) + 64'd2) / 64'd3);
  localparam logic [RW-1:0] RCP4 = RW'(((64'd1 << K) + 64'd3) / 64'd4);
  localparam logic [RW-1:0] RCP5 = RW'(((64'd1 << K) + 64'd4) / 64'd5);
  localparam logic [RW-1:0] RCP6 = RW'(((64'd1 << K) + 64'd5) / 64'd6);
  localparam logic [RW-1:0] RCP7 = RW'(((64'd1 << K) + 64'd6) / 64'd7);
  localparam logic [RW-1:0] RCP8 = RW'(((64'd1 << K) + 64'd7) / 64'd8);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [2:0]       k_r, k_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic             all_in_r, all_in_nxt;
  logic [ROW_W-1:0] rows_m1_r, rows_m1_nxt;
  logic [COL_W-1:0] cols_m1_r, cols_m1_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [ROW_W-1:0] r_r, r_nxt;
  logic [COL_W-1:0] c_r, c_nxt;
  logic             last_r, last_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [MEAN_W-1:0] o_mean_r, o_mean_nxt;
  logic [ROW_W-1:0] o_row_r, o_row_nxt;
  logic [COL_W-1:0] o_col_r, o_col_nxt;
  logic             o_last_r, o_last_nxt;

  logic                  in_acc;
  logic                  emit;
  logic                  pos_last;
  logic                  due;
  logic [ROW_W-1:0]      lr;
  logic [COL_W-1:0]      lc;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [PIXEL_BITS-1:0] wr_data;
  logic [QW-1:0]         px_ext;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  nb_ok;
  logic [1:0]            nb_row;
  logic [COL_W-1:0]      nb_col;
  logic                  has_up, has_dn, has_lf, has_rt;
  logic [RW-1:0]         recip;
  logic [QW-1:0]         quot_ext;
  logic [CW-1:0]         col_ext;
  logic [31:0]           cfg_cols_v;

  enmf_ring_ram #(
    .DATA_W (PIXEL_BITS),
    .ADDR_W (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign has_up = (r_r != '0);
  assign has_dn = (r_r != rows_m1_r);
  assign has_lf = (c_r != '0);
  assign has_rt = (c_r != cols_m1_r);

  always_comb begin
    nb_ok  = 1'b0;
    nb_row = r_r[1:0];
    nb_col = c_r;
    case (k_r)
      3'd0: begin
        nb_ok = has_up && has_lf; nb_row = r_r[1:0] - 2'd1; nb_col = c_r - COL_W'(1);
      end
      3'd1: begin
        nb_ok = has_up;           nb_row = r_r[1:0] - 2'd1; nb_col = c_r;
      end
      3'd2: begin
        nb_ok = has_up && has_rt; nb_row = r_r[1:0] - 2'd1; nb_col = c_r + COL_W'(1);
      end
      3'd3: begin
        nb_ok = has_lf;           nb_row = r_r[1:0];        nb_col = c_r - COL_W'(1);
      end
      3'd4: begin
        nb_ok = has_rt;           nb_row = r_r[1:0];        nb_col = c_r + COL_W'(1);
      end
      3'd5: begin
        nb_ok = has_dn && has_lf; nb_row = r_r[1:0] + 2'd1; nb_col = c_r - COL_W'(1);
      end
      3'd6: begin
        nb_ok = has_dn;           nb_row = r_r[1:0] + 2'd1; nb_col = c_r;
      end
      3'd7: begin
        nb_ok = has_dn && has_rt; nb_row = r_r[1:0] + 2'd1; nb_col = c_r + COL_W'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cnt_r)
      4'd1:    recip = RCP1;
      4'd2:    recip = RCP2;
      4'd3:    recip = RCP3;
      4'd4:    recip = RCP4;
      4'd5:    recip = RCP5;
      4'd6:    recip = RCP6;
      4'd7:    recip = RCP7;
      4'd8:    recip = RCP8;
      default: recip = '0;
    endcase
  end

  assign px_ext   = QW'(in_tdata);
  assign wr_data  = px_ext[PIXEL_BITS-1:0];
  assign wr_addr  = {in_row_r[1:0], in_col_r};
  assign rd_addr  = {nb_row, nb_col};
  assign rd_en    = (state_r == S_READ) && nb_ok;
  assign quot_ext = QW'(prod_r[K +: PIXEL_BITS]);
  assign cfg_cols_v = 32'(cfg_wdata[10:0]);

  assign lr  = (out_row_r != rows_m1_r) ? out_row_r + ROW_W'(1) : rows_m1_r;
  assign lc  = (out_col_r != cols_m1_r) ? out_col_r + COL_W'(1) : cols_m1_r;
  assign due = (lr < in_row_r) || ((lr == in_row_r) && (lc <= in_col_r));
  assign pos_last = (out_row_r == rows_m1_r) && (out_col_r == cols_m1_r);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    rd_vld_nxt    = rd_en;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    all_in_nxt    = all_in_r;
    rows_m1_nxt   = rows_m1_r;
    cols_m1_nxt   = cols_m1_r;
    out_valid_nxt = out_valid_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    last_nxt      = last_r;
    sum_nxt       = rd_vld_r ? sum_r + SW'(rd_data) : sum_r;
    cnt_nxt       = rd_en ? cnt_r + 4'd1 : cnt_r;
    prod_nxt      = prod_r;
    o_mean_nxt    = o_mean_r;
    o_row_nxt     = o_row_r;
    o_col_nxt     = o_col_r;
    o_last_nxt    = o_last_r;
    wr_en         = 1'b0;
    emit          = 1'b0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (all_in_r) begin
            emit = 1'b1;
          end else if (in_tuser == OP_PIXEL) begin
            wr_en = 1'b1;
            emit  = due;
            if (in_col_r == cols_m1_r) begin
              in_col_nxt = '0;
              if (in_row_r == rows_m1_r) begin
                in_row_nxt = '0;
                all_in_nxt = 1'b1;
              end else begin
                in_row_nxt = in_row_r + ROW_W'(1);
              end
            end else begin
              in_col_nxt = in_col_r + COL_W'(1);
            end
          end
        end
        if (emit) begin
          r_nxt     = out_row_r;
          c_nxt     = out_col_r;
          last_nxt  = pos_last;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          k_nxt     = '0;
          state_nxt = S_READ;
          if (pos_last) begin
            in_row_nxt  = '0;
            in_col_nxt  = '0;
            out_row_nxt = '0;
            out_col_nxt = '0;
            all_in_nxt  = 1'b0;
          end else if (out_col_r == cols_m1_r) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + ROW_W'(1);
          end else begin
            out_col_nxt = out_col_r + COL_W'(1);
          end
        end
      end
      S_READ: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PW'(sum_r) * PW'(recip);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          o_mean_nxt    = quot_ext[MEAN_W-1:0];
          o_row_nxt     = r_r;
          o_col_nxt     = c_r;
          o_last_nxt    = last_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_ROWS: begin
          if (cfg_wdata == '0) begin
            rows_m1_nxt = '0;
          end else if (cfg_wdata > CFG_W'(MAX_ROWS)) begin
            rows_m1_nxt = ROW_W'(MAX_ROWS - 1);
          end else begin
            rows_m1_nxt = ROW_W'(cfg_wdata - CFG_W'(1));
          end
        end
        CFG_FRAME_COLS: begin
          if (cfg_cols_v == 32'd0) begin
            cols_m1_nxt = '0;
          end else if (cfg_cols_v > 32'(MAX_COLS)) begin
            cols_m1_nxt = COLS_MAX_M1;
          end else begin
            cols_m1_nxt = COL_W'(cfg_cols_v - 32'd1);
          end
        end
        default: begin
          rows_m1_nxt = rows_m1_r;
        end
      endcase
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      all_in_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      in_row_r    <= '0;
      in_col_r    <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      all_in_r    <= 1'b0;
      rows_m1_r   <= '0;
      cols_m1_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rd_vld_r    <= rd_vld_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      all_in_r    <= all_in_nxt;
      rows_m1_r   <= rows_m1_nxt;
      cols_m1_r   <= cols_m1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    last_r   <= last_nxt;
    sum_r    <= sum_nxt;
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
    o_mean_r <= o_mean_nxt;
    o_row_r  <= o_row_nxt;
    o_col_r  <= o_col_nxt;
    o_last_r <= o_last_nxt;
  end

  assign col_ext    = CW'(o_col_r);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, col_ext[COL_IDX_W-1:0], o_row_r, o_mean_r};

  a_no_neighbour: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && cnt_r == 4'd0) |-> (rows_m1_r == '0 && cols_m1_r == '0))
    else $error("zero neighbour count outside a lone-pixel frame");

  a_all_in_pos: assert property (@(posedge clk) disable iff (!rst_n)
    all_in_r |-> (in_row_r == '0 && in_col_r == '0))
    else $error("input position not wrapped with frame complete");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_last_r) |-> (o_row_r == rows_m1_r && o_col_r == cols_m1_r))
    else $error("frame end flagged away from the last position");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cnt_r <= 4'd8 && k_r == 3'd0))
    else $error("neighbour count or read sequence out of step");

endmodule

// File: tb/eight_neighbor_mean_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for eight_neighbor_mean_filter: directed table, then random frames.
// Depends on enmf_pkg and the filter RTL; holds its own neighbour-mean predictor.
module eight_neighbor_mean_filter_tb;
  import enmf_pkg::*;

  localparam int COLS = MAX_COLS_DEF;

  typedef struct packed {
    logic [MEAN_W-1:0]    mean;
    logic [ROW_W-1:0]     row;
    logic [COL_IDX_W-1:0] col;
    logic                 last;
  } pos_mean_t;

  typedef enum logic {DIR_CFG, DIR_ITEM} dir_kind_t;

  typedef struct packed {
    dir_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic                 op;
    logic [7:0]           px;
    bit                   typed;
    bit                   has;
    pos_mean_t            res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [7:0] pixel
  logic                  in_tuser = 1'b0; // [0] op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [7:0] mean, [19:8] row_index, [29:20] col_index
  logic                  out_tlast;       // frame_end

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int errors = 0;
  int n_results = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  eight_neighbor_mean_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  logic [7:0]  nbr_ring [4][COLS];
  int unsigned rows_reg = 1;
  int unsigned cols_reg = 1;
  int unsigned px_row = 0, px_col = 0, owed_row = 0, owed_col = 0;
  bit          frame_full = 1'b0;
  pos_mean_t   mean_q [$];

  function automatic int unsigned eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > COLS) return COLS;
    return cols_reg;
  endfunction

  function automatic void restart_frame();
    px_row = 0;
    px_col = 0;
    owed_row = 0;
    owed_col = 0;
    frame_full = 1'b0;
  endfunction

  function automatic pos_mean_t owed_mean();
    int unsigned rows = eff_rows();
    int unsigned cols = eff_cols();
    int unsigned r = owed_row;
    int unsigned c = owed_col;
    int unsigned sum = 0;
    int unsigned cnt = 0;
    int          nr, nc;
    pos_mean_t   res;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr == 0 && dc == 0) continue;
        if (dr < 0 && r == 0) continue;
        if (dr > 0 && r + 1 >= rows) continue;
        if (dc < 0 && c == 0) continue;
        if (dc > 0 && c + 1 >= cols) continue;
        nr = int'(r) + dr;
        nc = int'(c) + dc;
        sum += nbr_ring[nr & 3][nc];
        cnt++;
      end
    end
    res.mean = (cnt == 0) ? '0 : MEAN_W'(sum / cnt);
    res.row  = ROW_W'(r);
    res.col  = COL_IDX_W'(c);
    res.last = (r == rows - 1) && (c == cols - 1);
    if (res.last) begin
      restart_frame();
    end else begin
      owed_col++;
      if (owed_col >= cols) begin
        owed_col = 0;
        owed_row++;
      end
    end
    return res;
  endfunction

  function automatic bit filter_step(input logic op, input logic [7:0] px,
                                     output pos_mean_t res);
    int unsigned rows = eff_rows();
    int unsigned cols = eff_cols();
    int unsigned ar, ac, lr, lc;
    res = '0;
    if (frame_full) begin
      res = owed_mean();
      return 1'b1;
    end
    if (op == OP_DRAIN) return 1'b0;
    ar = px_row;
    ac = px_col;
    nbr_ring[ar & 3][ac] = px;
    px_col++;
    if (px_col >= cols) begin
      px_col = 0;
      px_row++;
      if (px_row >= rows) begin
        px_row = 0;
        frame_full = 1'b1;
      end
    end
    lr = (owed_row + 1 < rows) ? owed_row + 1 : rows - 1;
    lc = (owed_col + 1 < cols) ? owed_col + 1 : cols - 1;
    if (lr < ar || (lr == ar && lc <= ac)) begin
      res = owed_mean();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic dir_row_t tab_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    return '{DIR_CFG, idx, val, OP_PIXEL, 8'h00, 1'b0, 1'b0, '0};
  endfunction

  function automatic dir_row_t tab_item(logic op, logic [7:0] px, bit typed = 1'b0,
                                        bit has = 1'b0, pos_mean_t res = '0);
    return '{DIR_ITEM, CFG_FRAME_ROWS, '0, op, px, typed, has, res};
  endfunction

  task automatic send(input logic op, input logic [7:0] px);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_FRAME_ROWS) rows_reg = val;
    else cols_reg = val & 13'h07FF;
    restart_frame();
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    pos_mean_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (mean_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: tdata %h tlast %b", $time, out_tdata, out_tlast);
      end else begin
        want = mean_q.pop_front();
        if (out_tdata[7:0] !== want.mean || out_tdata[19:8] !== want.row ||
            out_tdata[29:20] !== want.col || out_tlast !== want.last) begin
          errors++;
          $display("%0t mismatch: exp mean %0d row %0d col %0d last %b, got %0d %0d %0d %b",
                   $time, want.mean, want.row, want.col, want.last, out_tdata[7:0],
                   out_tdata[19:8], out_tdata[29:20], out_tlast);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL eight_neighbor_mean_filter");
    $finish;
  end

  initial begin
    dir_row_t    dir_tab [23];
    int          snd_pct [4] = '{0, 78, 0, 27};
    int          rcv_pct [4] = '{0, 0, 78, 27};
    int unsigned big_rows [6] = '{4096, 8191, 1, 0, 1, 3};
    int unsigned big_cols [6] = '{1, 2047, 1024, 1, 0, 1024};
    int unsigned rows, cols;
    int          n_items = 0;
    int          n_phases = 0;
    logic        op;
    logic [7:0]  px;
    bit          has;
    pos_mean_t   res;

    dir_tab = '{
      tab_item(OP_PIXEL, 8'hAB, 1'b1, 1'b1, '{8'd0, 12'd0, 10'd0, 1'b1}),
      tab_item(OP_DRAIN, 8'hFF, 1'b1, 1'b0),
      tab_cfg(CFG_FRAME_ROWS, 13'd0),
      tab_cfg(CFG_FRAME_COLS, 13'd0),
      tab_item(OP_PIXEL, 8'hFF, 1'b1, 1'b1, '{8'd0, 12'd0, 10'd0, 1'b1}),
      tab_cfg(CFG_FRAME_ROWS, 13'd2),
      tab_cfg(CFG_FRAME_COLS, 13'd2),
      tab_item(OP_DRAIN, 8'h00),
      tab_item(OP_PIXEL, 8'hFF),
      tab_item(OP_PIXEL, 8'hFF),
      tab_item(OP_DRAIN, 8'h5A),
      tab_item(OP_PIXEL, 8'hFF),
      tab_item(OP_PIXEL, 8'h00),
      tab_item(OP_PIXEL, 8'h4D),
      tab_item(OP_DRAIN, 8'h00),
      tab_item(OP_DRAIN, 8'h00),
      tab_cfg(CFG_FRAME_ROWS, 13'd1),
      tab_cfg(CFG_FRAME_COLS, 13'd3),
      tab_item(OP_PIXEL, 8'h00),
      tab_item(OP_PIXEL, 8'hFF),
      tab_item(OP_PIXEL, 8'h00),
      tab_item(OP_DRAIN, 8'h00),
      tab_item(OP_DRAIN, 8'h00)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == DIR_CFG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].val);
        n_phases++;
      end else begin
        send(dir_tab[i].op, dir_tab[i].px);
        n_items++;
        has = filter_step(dir_tab[i].op, dir_tab[i].px, res);
        if (dir_tab[i].typed) begin
          has = dir_tab[i].has;
          res = dir_tab[i].res;
        end
        if (has) mean_q.push_back(res);
      end
    end

    for (int ph = 0; ph < 20; ph++) begin
      if (ph < 6) begin
        rows = big_rows[ph];
        cols = big_cols[ph];
      end else begin
        rows = $urandom_range(5, 1);
        cols = $urandom_range(6, 1);
      end
      write_reg(CFG_FRAME_ROWS, CFG_W'(rows));
      write_reg(CFG_FRAME_COLS, CFG_W'(cols) | CFG_W'($urandom_range(3) << 11));
      snd_idle_pct  = snd_pct[ph % 4];
      rcv_stall_pct = rcv_pct[ph % 4];
      n_phases++;
      for (int k = 0; k < 40; k++) begin
        if (frame_full) op = ($urandom_range(99) < 90) ? OP_DRAIN : OP_PIXEL;
        else op = ($urandom_range(99) < 10) ? OP_DRAIN : OP_PIXEL;
        px = $urandom_range(255);
        send(op, px);
        n_items++;
        if (filter_step(op, px, res)) mean_q.push_back(res);
      end
    end

    settle();
    $display("Covered %0d input transfers over %0d frame settings and idle mixes,", n_items,
             n_phases);
    $display("with %0d results checked against the predictor.", n_results);
    if (errors == 0) begin
      $display("PASS eight_neighbor_mean_filter");
    end else begin
      $display("FAIL eight_neighbor_mean_filter");
    end
    $finish;
  end

endmodule
